// File: rtl/pfde_pkg.sv
package pfde_pkg;
    localparam int DispW = 128;
    localparam int DispH = 64;
    localparam int Pages = DispH / 8;
    localparam int FbBytes = DispW * Pages;
    localparam int AddrW = $clog2(FbBytes);
    localparam int ColW = $clog2(DispW);
    localparam int PageW = $clog2(Pages);

    typedef enum logic [2:0] {
        K_CLEAR = 3'd0,
        K_PIXEL = 3'd1,
        K_HLINE = 3'd2,
        K_VLINE = 3'd3,
        K_FILL  = 3'd4,
        K_BLIT  = 3'd5,
        K_READ  = 3'd6,
        K_NONE  = 3'd7
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DIVIDE,
        S_BLIT0,
        S_BLIT1,
        S_WALK,
        S_RD,
        S_RMW,
        S_READ_RD,
        S_READ_WAIT,
        S_OUT
    } state_t;
endpackage

// File: rtl/page_framebuffer_draw_engine_unit.sv
// Page framebuffer draw engine: a 128x64 monochrome store, one byte per column
// of eight rows, with bit 0 on top.
// Commands come in on the input channel (valid/stall); one command is handled
// at a time, and stall stays high while it runs. The store is one single-port
// read, one-port write RAM; each byte a draw touches costs a read, then a write.
// Pixel: one read, then one write. Hline: a read and a write per clipped
// column. Vline: a read and a write per page. Fill rectangle: walks all 128
// columns, with a test pass for each column and a read and a write per page
// of each column that lies inside. Blit byte: a 16-step divide of byte_index
// by the pages per column, then a read and a write per page touched. Read
// byte: read_data is read from the store into an output register and waits
// there until the receiver lowers out_stall; no new command is taken until
// it has gone.
// Clear (and reset) sweeps the 1024 bytes, one per cycle; after reset the
// engine takes no command until the sweep ends. The pen register is written on
// the cfg channel, whose ready is high only while the engine is idle.
module page_framebuffer_draw_engine_unit
    import pfde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic signed [15:0] x,
    input  logic signed [15:0] y,
    input  logic signed [15:0] x_last,
    input  logic signed [15:0] y_last,
    input  logic [15:0] width,
    input  logic [15:0] height,
    input  logic [15:0] byte_index,
    input  logic [7:0]  pixel_byte,
    input  logic [9:0]  read_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    state_t state_reg, state_next;
    logic pen_reg;
    logic [AddrW-1:0] clr_reg;
    // work list: column range and page range with edge masks
    logic [ColW-1:0] col_reg, col_end_reg;
    logic [PageW-1:0] pg_reg, pg_end_reg, pg_lo_reg;
    logic [7:0] m_first_reg, m_last_reg;
    logic fill_reg;            // fill: column test per column
    logic signed [15:0] fx_reg, fy_reg, fyend_reg;
    logic [15:0] fw_reg;
    logic col_ok_reg;
    // blit
    logic [15:0] q_reg, r_reg, rh_reg;
    logic [4:0] dcnt_reg;
    logic signed [15:0] bx_reg, by_reg;
    logic [7:0] bdata_reg;
    logic [AddrW-1:0] b_addr1_reg;
    logic [7:0] b_m1_reg;
    logic b_v1_reg;
    // rmw
    logic [AddrW-1:0] addr_reg;
    logic [7:0] mask_reg;
    logic [7:0] rd_reg;
    logic rd_oob_reg;
    logic out_valid_reg;
    state_t ret_reg;

    logic we;
    logic [AddrW-1:0] waddr, raddr;
    logic [7:0] wdata, rdata;

    pfde_store u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign cfg_ready = !in_stall;
    assign out_valid = out_valid_reg;
    assign read_data = rd_reg;
    logic acc;
    assign acc = in_valid && !in_stall;

    // vline clip for a column, shared by vline and fill
    function automatic logic [PageW+PageW+16:0] vclip(
        input logic signed [15:0] y1i, input logic signed [15:0] y2i);
        logic signed [16:0] a, b;
        logic ok;
        logic [PageW-1:0] p1, p2;
        logic [7:0] ma, mb;
        begin
            a = (y1i < 0) ? 17'sd0 : 17'(y1i);
            b = (y2i >= DispH) ? 17'(DispH - 1) : 17'(y2i);
            ok = !(b < a);
            p1 = a[PageW+2:3];
            p2 = b[PageW+2:3];
            ma = 8'hFF << a[2:0];
            mb = 8'hFF >> (3'd7 - b[2:0]);
            vclip = {ok, p1, p2, ma, mb};
        end
    endfunction

    logic vc_ok;
    logic [PageW-1:0] vc_p1, vc_p2;
    logic [7:0] vc_m1, vc_m2;
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            {vc_ok, vc_p1, vc_p2, vc_m1, vc_m2} = vclip(y, y_last);
        end
        else
        begin
            {vc_ok, vc_p1, vc_p2, vc_m1, vc_m2} = vclip(fy_reg, fyend_reg);
        end
    end

    // hline clip
    logic signed [15:0] hx1, hx2;
    assign hx1 = (x < 0) ? 16'sd0 : x;
    assign hx2 = (x_last >= DispW) ? 16'(DispW - 1) : x_last;
    logic h_ok;
    assign h_ok = (y >= 0) && (y < DispH) && !(hx2 < hx1);

    // page mask of the current walk step
    logic [7:0] walk_mask;
    always_comb
    begin
        walk_mask = 8'hFF;
        if (pg_reg == pg_lo_reg)
        begin
            walk_mask = walk_mask & m_first_reg;
        end
        if (pg_reg == pg_end_reg)
        begin
            walk_mask = walk_mask & m_last_reg;
        end
    end

    // fill: column inside test
    logic [ColW-1:0] fcol;
    logic [15:0] fd;
    logic fin;
    always_comb
    begin
        fcol = col_reg;
        fd = 16'({{(16-ColW){1'b0}}, fcol}) - fx_reg;
        fin = fd < fw_reg;
    end

    // blit address work after divide
    logic signed [15:0] bxpos;
    logic signed [15:0] bpage;
    logic signed [15:0] bpos;
    logic signed [16:0] bpos2;
    logic [2:0] boff;
    logic bxok;
    always_comb
    begin
        boff = by_reg[2:0];
        bxpos = bx_reg + q_reg;
        bxok = (bxpos >= 0) && (bxpos < DispW);
        bpage = by_reg >>> 3;
        bpos = bxpos + 16'((bpage + r_reg) * DispW);
        bpos2 = 17'(bpos) + 17'(DispW);
    end

    // divider step
    logic [16:0] dsub;
    logic [15:0] drm;
    assign drm = {r_reg[14:0], q_reg[15]};
    assign dsub = {1'b0, drm} - {1'b0, rh_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (kind_t'(kind))
                        K_CLEAR:  state_next = S_CLEAR;
                        K_PIXEL:  state_next = ((x >= 0) && (x < DispW) && (y >= 0)
                                      && (y < DispH)) ? S_RD : S_IDLE;
                        K_HLINE:  state_next = h_ok ? S_WALK : S_IDLE;
                        K_VLINE:  state_next = ((x >= 0) && (x < DispW) && vc_ok)
                                      ? S_WALK : S_IDLE;
                        K_FILL:   state_next = S_WALK;
                        K_BLIT:   state_next = ((-$signed({1'b0, height}) < 17'(y))
                                      && (y <= DispH)) ? S_DIVIDE : S_IDLE;
                        K_READ:   state_next = S_READ_RD;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR:     state_next = (clr_reg == AddrW'(FbBytes - 1)) ? S_IDLE : S_CLEAR;
            S_DIVIDE:    state_next = (dcnt_reg == 5'd15) ? S_BLIT0 : S_DIVIDE;
            S_BLIT0:     state_next = S_RD;
            S_BLIT1:     state_next = b_v1_reg ? S_RD : S_IDLE;
            S_WALK:      state_next = S_RD;
            S_RD:        state_next = S_RMW;
            S_RMW:       state_next = ret_reg;
            S_READ_RD:   state_next = S_READ_WAIT;
            S_READ_WAIT: state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        raddr = addr_reg;
        if (state_reg == S_READ_RD)
        begin
            raddr = addr_reg;
        end
        we = (state_reg == S_CLEAR) || (state_reg == S_RMW);
        waddr = (state_reg == S_CLEAR) ? clr_reg : addr_reg;
        wdata = (state_reg == S_CLEAR) ? 8'h00
            : (pen_reg ? (rdata & ~mask_reg) : (rdata | mask_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            pen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ret_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                pen_reg <= cfg_data;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == S_IDLE && acc && kind_t'(kind) == K_CLEAR)
            begin
                clr_reg <= '0;
            end
            if (state_reg == S_READ_WAIT)
            begin
                out_valid_reg <= 1'b1;
            end
            // choose where a finished rmw goes next
            if (state_reg == S_IDLE && acc)
            begin
                ret_reg <= S_IDLE;
            end
            if (state_reg == S_WALK)
            begin
                ret_reg <= S_WALK;
                if (fill_reg)
                begin
                    if (!col_ok_reg)
                    begin
                        // a skipped last column ends the fill
                        if (!(fin && vc_ok) && col_reg == ColW'(DispW - 1))
                        begin
                            ret_reg <= S_IDLE;
                        end
                    end
                    else if (pg_reg == pg_end_reg && col_reg == ColW'(DispW - 1))
                    begin
                        ret_reg <= S_IDLE;
                    end
                end
                else if (col_reg == col_end_reg && pg_reg == pg_end_reg)
                begin
                    ret_reg <= S_IDLE;
                end
            end
            if (state_reg == S_BLIT0)
            begin
                ret_reg <= S_BLIT1;
            end
            if (state_reg == S_BLIT1)
            begin
                ret_reg <= S_IDLE;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ_WAIT)
        begin
            rd_reg <= rd_oob_reg ? 8'h00 : rdata;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                fill_reg <= 1'b0;
                col_ok_reg <= 1'b1;
                fx_reg <= x;
                fy_reg <= y;
                fyend_reg <= 16'(y + $signed(height) - 16'sd1);
                fw_reg <= width;
                bx_reg <= x;
                by_reg <= y;
                bdata_reg <= pixel_byte;
                q_reg <= byte_index;
                r_reg <= '0;
                dcnt_reg <= '0;
                rh_reg <= (height == 16'd0) ? 16'd1 : 16'(17'd1 + ((height - 16'd1) >> 3));
                rd_oob_reg <= {1'b0, read_address} >= 11'(FbBytes);
                addr_reg <= AddrW'(read_address);
                case (kind_t'(kind))
                    K_PIXEL:
                    begin
                        addr_reg <= AddrW'(x[ColW-1:0]) + AddrW'(y[PageW+2:3]) * AddrW'(DispW);
                        mask_reg <= 8'd1 << y[2:0];
                    end
                    K_HLINE:
                    begin
                        col_reg <= hx1[ColW-1:0];
                        col_end_reg <= hx2[ColW-1:0];
                        pg_reg <= y[PageW+2:3];
                        pg_lo_reg <= y[PageW+2:3];
                        pg_end_reg <= y[PageW+2:3];
                        m_first_reg <= 8'd1 << y[2:0];
                        m_last_reg <= 8'hFF;
                    end
                    K_VLINE:
                    begin
                        col_reg <= x[ColW-1:0];
                        col_end_reg <= x[ColW-1:0];
                        pg_reg <= vc_p1;
                        pg_lo_reg <= vc_p1;
                        pg_end_reg <= vc_p2;
                        m_first_reg <= vc_m1;
                        m_last_reg <= vc_m2;
                    end
                    K_FILL:
                    begin
                        fill_reg <= 1'b1;
                        col_reg <= '0;
                        col_ok_reg <= 1'b0;
                        pg_reg <= '0;
                        pg_end_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DIVIDE:
            begin
                dcnt_reg <= dcnt_reg + 5'd1;
                if (!dsub[16])
                begin
                    r_reg <= dsub[15:0];
                    q_reg <= {q_reg[14:0], 1'b1};
                end
                else
                begin
                    r_reg <= drm;
                    q_reg <= {q_reg[14:0], 1'b0};
                end
            end
            S_BLIT0:
            begin
                addr_reg <= bpos[AddrW-1:0];
                mask_reg <= (bxok && bpos >= 0 && bpos < FbBytes)
                    ? (bdata_reg << boff) : 8'h00;
                b_addr1_reg <= bpos2[AddrW-1:0];
                b_m1_reg <= (boff == 3'd0) ? 8'h00 : (bdata_reg >> (4'd8 - {1'b0, boff}));
                b_v1_reg <= bxok && bpos2 >= 0 && bpos2 < FbBytes;
            end
            S_BLIT1:
            begin
                addr_reg <= b_addr1_reg;
                mask_reg <= b_m1_reg;
            end
            S_WALK:
            begin
                if (fill_reg && !col_ok_reg)
                begin
                    // new column: decide and set page range
                    mask_reg <= 8'h00;
                    addr_reg <= '0;
                    if (fin && vc_ok)
                    begin
                        col_ok_reg <= 1'b1;
                        pg_reg <= vc_p1;
                        pg_lo_reg <= vc_p1;
                        pg_end_reg <= vc_p2;
                        m_first_reg <= vc_m1;
                        m_last_reg <= vc_m2;
                    end
                    else if (col_reg != ColW'(DispW - 1))
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                else
                begin
                    addr_reg <= AddrW'(col_reg) + AddrW'(pg_reg) * AddrW'(DispW);
                    mask_reg <= walk_mask;
                    if (pg_reg != pg_end_reg)
                    begin
                        pg_reg <= pg_reg + 1'b1;
                    end
                    else if (fill_reg)
                    begin
                        col_ok_reg <= 1'b0;
                        if (col_reg != ColW'(DispW - 1))
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                    else if (col_reg != col_end_reg)
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule

// File: rtl/pfde_store.sv
module pfde_store
    import pfde_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [7:0]       wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [7:0]       rdata
);
    logic [7:0] mem [FbBytes];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/pfde_checker.sv
module pfde_checker
    import pfde_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [2:0] kind,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] read_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data))
        else $error("result dropped while stalled");
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("command taken while result pending");
    a_read_res: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == K_READ |-> ##3 out_valid)
        else $error("read gave no result");
    a_no_res: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind != K_READ |-> ##3 !out_valid)
        else $error("result without read");
endmodule

bind page_framebuffer_draw_engine_unit pfde_checker u_pfde_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_data(read_data)
);
